// ----- src/ufe_pkg.sv -----
package ufe_pkg;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIELD_ESCAPE  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEP_BRACKETS = 4'd1;

   // escape and marker bytes
   localparam logic [7:0] BACKSLASH    = 8'h5C;
   localparam logic [7:0] RUN_MARK_HI  = 8'hC2;  // U+00A4, first byte
   localparam logic [7:0] RUN_MARK_LO  = 8'hA4;  // U+00A4, second byte
   localparam logic [7:0] BRAILLE_LEAD = 8'hE2;  // U+2800 block lead
   localparam logic [5:0] BRAILLE_MID  = 6'b101000;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   localparam logic [20:0] CP_C1_LOW     = 21'h000080;
   localparam logic [20:0] CP_C1_HIGH    = 21'h00009F;
   localparam logic [20:0] CP_CURRENCY   = 21'h0000A4;
   localparam logic [20:0] CP_TWO_MIN    = 21'h000080;
   localparam logic [20:0] CP_THREE_MIN  = 21'h000800;
   localparam logic [20:0] CP_SURR_LOW   = 21'h00D800;
   localparam logic [20:0] CP_SURR_HIGH  = 21'h00DFFF;
   localparam logic [20:0] CP_FOUR_MIN   = 21'h010000;
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] CP_REPLACE    = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } ufe_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } ufe_rsp_type;

   typedef struct packed {
      logic field_escape;
      logic keep_brackets;
   } ufe_cfg_type;

   // one entry per accepted byte that yields output:
   // tier 3 bytes first, then a tier 1/2 tail, then end of name
   typedef struct packed {
      logic [3:0][7:0] t3_bytes;
      logic [2:0]      t3_cnt;
      logic [3:0][7:0] tail_bytes;
      logic [2:0]      tail_cnt;
      logic            last;
   } ufe_entry_type;

   typedef enum logic [3:0] {
      STEP_NEW,
      STEP_NONE,
      STEP_OPEN_HI,
      STEP_OPEN_LO,
      STEP_BR0,
      STEP_BR1,
      STEP_BR2,
      STEP_CLOSE_HI,
      STEP_CLOSE_LO,
      STEP_TAIL,
      STEP_FIN_HI,
      STEP_FIN_LO
   } ufe_step_type;

endpackage

// ----- src/ufe_front.sv -----
module ufe_front
   import ufe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ufe_cfg_type   cfg,
   input  logic          push,
   output logic          full,
   input  ufe_req_type   req_data,
   input  logic          q_full,
   output logic          entry_push,
   output ufe_entry_type entry_data
);

   logic [7:0] held_bytes_ff [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] needed_count_ff, needed_count_in;

   logic       accept;
   logic [7:0] b;
   logic       last;
   logic       held, cont, case_a, start, complete;
   logic       ascii, lead2, lead3, lead4, lead;
   logic [3:0][7:0] seq;
   logic [20:0] cp;
   logic       cp_ok, mb_tier1;
   logic       a_tier1, a_tier2, a_prefix;
   logic       a_t3, b_start_t3, include_held, include_b;
   logic       held_wr;
   logic [1:0] held_wr_idx;

   function automatic logic [7:0] tier2_char(input logic [7:0] c);
      logic [7:0] r;
      r = BACKSLASH;
      unique case (c)
         CHAR_NUL: r = 8'h30;
         CHAR_TAB: r = 8'h74;
         CHAR_LF:  r = 8'h6E;
         CHAR_CR:  r = 8'h72;
         default:  r = BACKSLASH;
      endcase
      return r;
   endfunction

   assign full   = q_full;
   assign accept = push && !q_full;
   assign b      = req_data.in_byte;
   assign last   = req_data.in_last;

   assign held     = held_count_ff != 2'd0;
   assign cont     = b[7:6] == CONT_TAG;
   assign case_a   = held && cont;
   assign start    = !case_a;
   assign complete = held_count_ff == needed_count_ff;

   assign ascii = !b[7];
   assign lead2 = b[7:5] == 3'b110;
   assign lead3 = b[7:4] == 4'b1110;
   assign lead4 = b[7:3] == 5'b11110;
   assign lead  = lead2 || lead3 || lead4;

   // sequence so far with the new byte placed after the held ones
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         seq[i] = (2'(i) == held_count_ff) ? b : held_bytes_ff[i];
      end
      seq[3] = b;
   end

   always_comb begin
      cp    = '0;
      cp_ok = 1'b0;
      unique case (held_count_ff)
         2'd1: begin
            cp    = {10'd0, seq[0][4:0], seq[1][5:0]};
            cp_ok = cp >= CP_TWO_MIN;
         end
         2'd2: begin
            cp    = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
            cp_ok = cp >= CP_THREE_MIN && (cp < CP_SURR_LOW || cp > CP_SURR_HIGH);
         end
         2'd3: begin
            cp    = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
            cp_ok = cp >= CP_FOUR_MIN && cp <= CP_MAX;
         end
         default: begin
            cp    = '0;
            cp_ok = 1'b0;
         end
      endcase
   end

   assign mb_tier1 = cp_ok && !(cp >= CP_C1_LOW && cp <= CP_C1_HIGH)
                     && cp != CP_REPLACE && cp != CP_CURRENCY;

   assign a_tier1  = ascii && b >= CHAR_SPACE && b != CHAR_DEL && b != BACKSLASH;
   assign a_tier2  = b == CHAR_NUL || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR
                     || b == BACKSLASH;
   assign a_prefix = cfg.field_escape && (b == CHAR_SPACE || b == CHAR_QUOTE ||
                     (!cfg.keep_brackets && (b == CHAR_LBRACK || b == CHAR_RBRACK)));

   assign a_t3       = case_a && ((complete && !mb_tier1) || (!complete && last));
   assign b_start_t3 = start && ((ascii && !a_tier1 && !a_tier2) ||
                                 (!ascii && !lead) || (lead && last));
   assign include_held = held && (!cont || a_t3);
   assign include_b    = a_t3 || b_start_t3;

   always_comb begin
      entry_data.t3_bytes   = seq;
      entry_data.t3_cnt     = (include_held ? {1'b0, held_count_ff} : 3'd0)
                              + {2'd0, include_b};
      entry_data.tail_bytes = seq;
      entry_data.tail_cnt   = 3'd0;
      entry_data.last       = last;
      priority if (case_a && complete && mb_tier1) begin
         entry_data.tail_cnt = {1'b0, held_count_ff} + 3'd1;
      end else if (start && a_tier1) begin
         if (a_prefix) begin
            entry_data.tail_bytes[0] = BACKSLASH;
            entry_data.tail_bytes[1] = b;
            entry_data.tail_cnt      = 3'd2;
         end else begin
            entry_data.tail_bytes[0] = b;
            entry_data.tail_cnt      = 3'd1;
         end
      end else if (start && ascii && a_tier2) begin
         entry_data.tail_bytes[0] = BACKSLASH;
         entry_data.tail_bytes[1] = tier2_char(b);
         entry_data.tail_cnt      = 3'd2;
      end else begin
         entry_data.tail_cnt = 3'd0;
      end
   end

   assign entry_push = accept &&
                       (entry_data.t3_cnt != 3'd0 || entry_data.tail_cnt != 3'd0 || last);

   always_comb begin
      held_count_in   = 2'd0;
      needed_count_in = 2'd0;
      held_wr         = 1'b0;
      held_wr_idx     = 2'd0;
      priority if (case_a && !complete) begin
         held_wr         = 1'b1;
         held_wr_idx     = held_count_ff;
         held_count_in   = held_count_ff + 2'd1;
         needed_count_in = needed_count_ff;
      end else if (start && lead) begin
         held_wr         = 1'b1;
         held_count_in   = 2'd1;
         needed_count_in = lead2 ? 2'd1 : (lead3 ? 2'd2 : 2'd3);
      end else begin
         held_count_in   = 2'd0;
         needed_count_in = 2'd0;
      end
      if (last) begin
         held_count_in   = 2'd0;
         needed_count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff   <= 2'd0;
         needed_count_ff <= 2'd0;
      end else if (accept) begin
         held_count_ff   <= held_count_in;
         needed_count_ff <= needed_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_wr) begin
         held_bytes_ff[held_wr_idx] <= b;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> held_count_ff == 2'd0 && needed_count_ff == 2'd0)
      else $error("held sequence survives end of name");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> needed_count_ff >= held_count_ff)
      else $error("held byte count exceeds sequence length");

endmodule

// ----- src/ufe_queue.sv -----
module ufe_queue
   import ufe_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  ufe_entry_type wr_data,
   output logic          full,
   input  logic          rd_en,
   output ufe_entry_type rd_data,
   output logic          empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ufe_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (rd_en) rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (wr_en && !rd_en) count_ff <= count_ff + CNT_W'(1);
         else if (rd_en && !wr_en) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wr_ptr_ff] <= wr_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("entry written into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("entry read from empty queue");

endmodule

// ----- src/ufe_back.sv -----
module ufe_back
   import ufe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ufe_entry_type head,
   input  logic          head_valid,
   output logic          head_pop,
   output logic          empty,
   input  logic          pop,
   output ufe_rsp_type   rsp_data
);

   ufe_step_type step_ff, step_in, eff_step, step_next;
   logic [1:0]   idx_ff, idx_in, idx_next;
   logic [2:0]   idx_inc;
   logic         run_open_ff, run_open_in;
   logic         rsp_valid_ff, rsp_valid_in;
   ufe_rsp_type  rsp_data_ff, rsp_in;
   logic         done, load, advance;
   logic [7:0]   cur_t3;

   assign idx_inc = {1'b0, idx_ff} + 3'd1;
   assign cur_t3  = head.t3_bytes[idx_ff];

   // start of an entry: pick its first byte from the run state
   always_comb begin
      eff_step = step_ff;
      if (step_ff == STEP_NEW) begin
         priority if (head.t3_cnt != 3'd0) begin
            eff_step = run_open_ff ? STEP_BR0 : STEP_OPEN_HI;
         end else if (head.tail_cnt != 3'd0) begin
            eff_step = run_open_ff ? STEP_CLOSE_HI : STEP_TAIL;
         end else if (head.last && run_open_ff) begin
            eff_step = STEP_FIN_HI;
         end else begin
            eff_step = STEP_NONE;
         end
      end
   end

   // next state
   always_comb begin
      step_next = eff_step;
      idx_next  = idx_ff;
      done      = 1'b0;
      unique case (eff_step)
         STEP_OPEN_HI:  step_next = STEP_OPEN_LO;
         STEP_OPEN_LO:  step_next = STEP_BR0;
         STEP_BR0:      step_next = STEP_BR1;
         STEP_BR1:      step_next = STEP_BR2;
         STEP_BR2: begin
            priority if (idx_inc < head.t3_cnt) begin
               step_next = STEP_BR0;
               idx_next  = idx_ff + 2'd1;
            end else if (head.tail_cnt != 3'd0) begin
               step_next = STEP_CLOSE_HI;
            end else if (head.last) begin
               step_next = STEP_FIN_HI;
            end else begin
               done = 1'b1;
            end
         end
         STEP_CLOSE_HI: step_next = STEP_CLOSE_LO;
         STEP_CLOSE_LO: begin
            step_next = STEP_TAIL;
            idx_next  = 2'd0;
         end
         STEP_TAIL: begin
            if (idx_inc < head.tail_cnt) idx_next = idx_ff + 2'd1;
            else done = 1'b1;
         end
         STEP_FIN_HI:   step_next = STEP_FIN_LO;
         STEP_FIN_LO:   done = 1'b1;
         default:       done = 1'b1;
      endcase
   end

   assign load     = head_valid && eff_step != STEP_NONE && (!rsp_valid_ff || pop);
   assign advance  = load || (head_valid && eff_step == STEP_NONE);
   assign head_pop = advance && done;

   always_comb begin
      step_in = step_ff;
      idx_in  = idx_ff;
      if (advance) begin
         step_in = done ? STEP_NEW : step_next;
         idx_in  = done ? 2'd0 : idx_next;
      end
   end

   // outputs
   always_comb begin
      rsp_in.out_byte = RUN_MARK_HI;
      rsp_in.out_last = done && head.last;
      run_open_in     = run_open_ff;
      unique case (eff_step)
         STEP_OPEN_HI, STEP_CLOSE_HI, STEP_FIN_HI: rsp_in.out_byte = RUN_MARK_HI;
         STEP_OPEN_LO: begin
            rsp_in.out_byte = RUN_MARK_LO;
            run_open_in     = load ? 1'b1 : run_open_ff;
         end
         STEP_CLOSE_LO, STEP_FIN_LO: begin
            rsp_in.out_byte = RUN_MARK_LO;
            run_open_in     = load ? 1'b0 : run_open_ff;
         end
         STEP_BR0:  rsp_in.out_byte = BRAILLE_LEAD;
         STEP_BR1:  rsp_in.out_byte = {BRAILLE_MID, cur_t3[7:6]};
         STEP_BR2:  rsp_in.out_byte = {CONT_TAG, cur_t3[5:0]};
         STEP_TAIL: rsp_in.out_byte = head.tail_bytes[idx_ff];
         default:   rsp_in.out_byte = RUN_MARK_HI;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (pop ? 1'b0 : rsp_valid_ff);
   assign empty        = !rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_NEW;
         idx_ff       <= 2'd0;
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         run_open_ff  <= run_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= rsp_in;
   end

   a_last_closes_run: assert property (@(posedge clock) disable iff (reset)
      load && rsp_in.out_last |=> !run_open_ff)
      else $error("marker run still open after final byte");

   a_mid_entry_head: assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_NEW |-> head_valid)
      else $error("entry in progress without queue head");

endmodule

// ----- src/utf8_filename_escape_encoder_unit.sv -----
// A byte that yields output shows its first result byte after the queue and output register.
// Throughput: one input byte per cycle while the entry queue has room; the back end
// sends one result byte per cycle while its output is popped, so a byte yielding n result
// bytes (up to 16) keeps it busy and the QUEUE_DEPTH-entry queue absorbs the difference.
// Reset (synchronous): clears the held sequence, the marker run, the queue, the output
// register and both configuration registers at once; no clearing pass.
module utf8_filename_escape_encoder_unit
   import ufe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  ufe_req_type                req_data,
   output logic                       empty,
   input  logic                       pop,
   output ufe_rsp_type                rsp_data,
   input  logic                       valid,
   output logic                       ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   ufe_cfg_type   cfg_ff, cfg_in;
   logic          q_full, q_empty, q_wr, q_rd;
   ufe_entry_type q_wr_data, q_rd_data;

   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_FIELD_ESCAPE:  cfg_in.field_escape  = csr_data[0];
            CSR_KEEP_BRACKETS: cfg_in.keep_brackets = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   ufe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .q_full     (q_full),
      .entry_push (q_wr),
      .entry_data (q_wr_data)
   );

   ufe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_rd),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   ufe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_rd_data),
      .head_valid (!q_empty),
      .head_pop   (q_rd),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ufe_pkg::*;

   class escape_scoreboard;
      logic [2:0][7:0] held;
      int              held_cnt;
      int              need_cnt;
      bit              run_open;
      bit              field_escape;
      bit              keep_brackets;
      ufe_rsp_type     step_q[$];
      ufe_rsp_type     expected_q[$];
      int              errors;

      function new();
         held = '0;
         held_cnt = 0;
         need_cnt = 0;
         run_open = 0;
         field_escape = 0;
         keep_brackets = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == CSR_FIELD_ESCAPE) begin
            field_escape = data[0];
         end else if (idx == CSR_KEEP_BRACKETS) begin
            keep_brackets = data[0];
         end
      endfunction

      function void emit(logic [7:0] b);
         ufe_rsp_type r;
         r.out_byte = b;
         r.out_last = 1'b0;
         if (step_q.size() < 16) step_q.push_back(r);
      endfunction

      function void close_run();
         if (run_open) begin
            emit(RUN_MARK_HI);
            emit(RUN_MARK_LO);
            run_open = 0;
         end
      endfunction

      // raw byte as U+2800+byte, opening a marked run if needed
      function void emit_braille(logic [7:0] b);
         if (!run_open) begin
            emit(RUN_MARK_HI);
            emit(RUN_MARK_LO);
            run_open = 1;
         end
         emit(BRAILLE_LEAD);
         emit({BRAILLE_MID, b[7:6]});
         emit({CONT_TAG, b[5:0]});
      endfunction

      function bit is_printable(logic [20:0] cp);
         if (cp < 21'h20 || cp == {13'b0, CHAR_DEL}) return 0;
         if (cp >= CP_C1_LOW && cp <= CP_C1_HIGH) return 0;
         return cp != CP_REPLACE;
      endfunction

      function void encode_point(logic [20:0] cp, logic [3:0][7:0] seq, int n);
         logic [7:0] esc;
         logic [7:0] c;
         c = seq[0];
         if (is_printable(cp) && cp != CP_CURRENCY && cp != {13'b0, BACKSLASH}) begin
            close_run();
            if (n == 1 && field_escape && (c == CHAR_SPACE || c == CHAR_QUOTE ||
                  (!keep_brackets && (c == CHAR_LBRACK || c == CHAR_RBRACK))))
               emit(BACKSLASH);
            for (int i = 0; i < n; i++) emit(seq[i]);
            return;
         end
         esc = 8'h00;
         if (cp[20:8] == '0) begin
            case (cp[7:0])
               CHAR_NUL:  esc = "0";
               CHAR_TAB:  esc = "t";
               CHAR_LF:   esc = "n";
               CHAR_CR:   esc = "r";
               BACKSLASH: esc = BACKSLASH;
               default:   esc = 8'h00;
            endcase
         end
         if (esc != 8'h00) begin
            close_run();
            emit(BACKSLASH);
            emit(esc);
         end else begin
            for (int i = 0; i < n; i++) emit_braille(seq[i]);
         end
      endfunction

      function void flush_held();
         for (int i = 0; i < held_cnt; i++) emit_braille(held[i]);
         held_cnt = 0;
         need_cnt = 0;
      endfunction

      function void start_byte(logic [7:0] b);
         logic [3:0][7:0] seq;
         seq = '0;
         seq[0] = b;
         if (b < 8'h80) begin
            encode_point({13'b0, b}, seq, 1);
         end else if (b >= 8'hC0 && b <= 8'hDF) begin
            held[0] = b;
            held_cnt = 1;
            need_cnt = 1;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            held[0] = b;
            held_cnt = 1;
            need_cnt = 2;
         end else if (b >= 8'hF0 && b <= 8'hF7) begin
            held[0] = b;
            held_cnt = 1;
            need_cnt = 3;
         end else begin
            emit_braille(b);
         end
      endfunction

      // overlong, surrogate and out-of-range sequences go to the marked run whole
      function void finish_sequence(logic [3:0][7:0] seq, int n);
         logic [20:0] cp;
         bit          ok;
         case (n)
            2: begin
               cp = {10'b0, seq[0][4:0], seq[1][5:0]};
               ok = cp >= CP_TWO_MIN;
            end
            3: begin
               cp = {5'b0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
               ok = cp >= CP_THREE_MIN && (cp < CP_SURR_LOW || cp > CP_SURR_HIGH);
            end
            default: begin
               cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
               ok = cp >= CP_FOUR_MIN && cp <= CP_MAX;
            end
         endcase
         if (ok) begin
            encode_point(cp, seq, n);
         end else begin
            for (int i = 0; i < n; i++) emit_braille(seq[i]);
         end
      endfunction

      function void note_byte(ufe_req_type item);
         logic [3:0][7:0] seq;
         logic [7:0]      b;
         int              n;
         b = item.in_byte;
         seq = '0;
         step_q.delete();
         if (held_cnt != 0) begin
            if (b[7:6] == CONT_TAG) begin
               for (int i = 0; i < held_cnt; i++) seq[i] = held[i];
               seq[held_cnt] = b;
               n = held_cnt + 1;
               if (n >= need_cnt + 1) begin
                  held_cnt = 0;
                  need_cnt = 0;
                  finish_sequence(seq, n);
               end else begin
                  held[held_cnt] = b;
                  held_cnt++;
               end
            end else begin
               flush_held();
               start_byte(b);
            end
         end else begin
            start_byte(b);
         end
         if (item.in_last) begin
            flush_held();
            close_run();
            if (step_q.size() > 0) step_q[step_q.size() - 1].out_last = 1'b1;
         end
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void check_byte(ufe_rsp_type got);
         ufe_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected output, expected none, got byte %h last %b",
                     $time, got.out_byte, got.out_last);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, got %h",
                     $time, want.out_byte, got.out_byte);
            errors++;
         end
         if (got.out_last !== want.out_last) begin
            $display("%0t: out_last mismatch, expected %b, got %b",
                     $time, want.out_last, got.out_last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       push = 1'b0;
   logic                       full;
   ufe_req_type                req_data = '0;
   logic                       empty;
   logic                       pop = 1'b0;
   ufe_rsp_type                rsp_data;
   logic                       valid = 1'b0;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   int                tx_idle = 12;
   int                rx_idle = 87;
   logic [7:0]        name_bytes[$];
   escape_scoreboard  sb;

   utf8_filename_escape_encoder_unit uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      pop <= !reset && ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (valid && ready) sb.note_csr(csr_index, csr_data);
         if (push && !full) sb.note_byte(req_data);
         if (pop && !empty) sb.check_byte(rsp_data);
      end
   end

   initial begin
      #(1_000_000 * 12);
      $display("** utf8_filename_escape_encoder_unit: FAILED **");
      $finish;
   end

   function automatic logic [7:0] pick(int lo, int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // one code point, well formed or deliberately broken
   function automatic void add_token();
      logic [7:0] lead;
      int         kind;
      kind = $urandom_range(15);
      case (kind)
         0, 1, 2: name_bytes.push_back(pick(8'h20, 8'h7E));
         3: begin
            case ($urandom_range(4))
               0:       name_bytes.push_back(CHAR_SPACE);
               1:       name_bytes.push_back(CHAR_QUOTE);
               2:       name_bytes.push_back(CHAR_LBRACK);
               3:       name_bytes.push_back(CHAR_RBRACK);
               default: name_bytes.push_back(BACKSLASH);
            endcase
         end
         4: begin
            case ($urandom_range(5))
               0:       name_bytes.push_back(CHAR_NUL);
               1:       name_bytes.push_back(CHAR_TAB);
               2:       name_bytes.push_back(CHAR_LF);
               3:       name_bytes.push_back(CHAR_CR);
               4:       name_bytes.push_back(CHAR_DEL);
               default: name_bytes.push_back(pick(8'h00, 8'h1F));
            endcase
         end
         5: begin
            name_bytes.push_back(pick(8'hC2, 8'hDF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         6: begin
            // currency sign or a C1 control
            name_bytes.push_back(8'hC2);
            name_bytes.push_back($urandom_range(1) ? 8'hA4 : pick(8'h80, 8'h9F));
         end
         7, 8: begin
            lead = pick(8'hE0, 8'hEF);
            name_bytes.push_back(lead);
            if (lead == 8'hE0) name_bytes.push_back(pick(8'hA0, 8'hBF));
            else if (lead == 8'hED) name_bytes.push_back(pick(8'h80, 8'h9F));
            else name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         9: begin
            name_bytes.push_back(8'hEF);
            name_bytes.push_back(8'hBF);
            name_bytes.push_back(8'hBD);
         end
         10: begin
            lead = pick(8'hF0, 8'hF4);
            name_bytes.push_back(lead);
            if (lead == 8'hF0) name_bytes.push_back(pick(8'h90, 8'hBF));
            else if (lead == 8'hF4) name_bytes.push_back(pick(8'h80, 8'h8F));
            else name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         11: begin
            // range failures: overlong, surrogate, above the last code point
            case ($urandom_range(4))
               0: begin
                  name_bytes.push_back(pick(8'hC0, 8'hC1));
                  name_bytes.push_back(pick(8'h80, 8'hBF));
               end
               1: begin
                  name_bytes.push_back(8'hE0);
                  name_bytes.push_back(pick(8'h80, 8'h9F));
                  name_bytes.push_back(pick(8'h80, 8'hBF));
               end
               2: begin
                  name_bytes.push_back(8'hED);
                  name_bytes.push_back(pick(8'hA0, 8'hBF));
                  name_bytes.push_back(pick(8'h80, 8'hBF));
               end
               3: begin
                  name_bytes.push_back(8'hF4);
                  name_bytes.push_back(pick(8'h90, 8'hBF));
                  name_bytes.push_back(pick(8'h80, 8'hBF));
                  name_bytes.push_back(pick(8'h80, 8'hBF));
               end
               default: begin
                  name_bytes.push_back(pick(8'hF5, 8'hF7));
                  repeat (3) name_bytes.push_back(pick(8'h80, 8'hBF));
               end
            endcase
         end
         12: begin
            // truncated sequence
            lead = pick(8'hC0, 8'hF7);
            name_bytes.push_back(lead);
            repeat ($urandom_range(lead >= 8'hF0 ? 2 : (lead >= 8'hE0 ? 1 : 0)))
               name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         13, 14: name_bytes.push_back(pick(8'h00, 8'hFF));
         default: name_bytes.push_back(pick(8'h80, 8'hBF));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_data.in_byte = b;
      req_data.in_last = last;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic send_name();
      foreach (name_bytes[i]) send_byte(name_bytes[i], i == name_bytes.size() - 1);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      @(negedge clock);
      valid = 1'b0;
   endtask

   // registers change only with the output drained
   task automatic set_mode(input logic fe, input logic kb);
      while (sb.pending() > 0) @(negedge clock);
      repeat (6) @(negedge clock);
      write_csr(CSR_FIELD_ESCAPE, {7'($urandom_range(127)), fe});
      write_csr(CSR_KEEP_BRACKETS, {7'($urandom_range(127)), kb});
      write_csr(CSR_INDEX_WIDTH'($urandom_range(15, 2)), 8'($urandom));
   endtask

   initial begin
      int         sent;
      int         names;
      logic [1:0] mode_sel;
      sb = new();
      mode_sel = 2'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_mode(1'b1, 1'b0);
      name_bytes = '{8'h41, CHAR_SPACE, CHAR_QUOTE, CHAR_LBRACK, CHAR_RBRACK, CHAR_NUL,
                     CHAR_TAB, CHAR_LF, CHAR_CR, BACKSLASH, CHAR_DEL, 8'hFF};
      send_name();
      name_bytes = '{8'hC2, 8'h80, 8'hC2, 8'hA4, 8'hEF, 8'hBF, 8'hBD, 8'hC0, 8'h80,
                     8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h80,
                     8'hE2, 8'h41, 8'hE2, 8'h82};
      send_name();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle = 12;
               rx_idle = 87;
            end
            1: begin
               tx_idle = 87;
               rx_idle = 12;
            end
            default: begin
               tx_idle = 0;
               rx_idle = 0;
            end
         endcase
         sent = 0;
         names = 0;
         while (sent < 110) begin
            if (names % 4 == 0) begin
               set_mode(mode_sel[0] ^ mode_sel[1], mode_sel[1]);
               mode_sel++;
            end
            name_bytes.delete();
            repeat ($urandom_range(8, 1)) add_token();
            send_name();
            sent += name_bytes.size();
            names++;
         end
      end

      while (sb.pending() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** utf8_filename_escape_encoder_unit: PASSED **");
      end else begin
         $display("** utf8_filename_escape_encoder_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/ufe_pkg.sv
src/ufe_front.sv
src/ufe_queue.sv
src/ufe_back.sv
src/utf8_filename_escape_encoder_unit.sv
tb/testbench.sv
